// File: rtl/defrag_gap_run_selector_defines.svh
// assertion macros shared by the gap run selector rtl
`ifndef DEFRAG_GAP_RUN_SELECTOR_DEFINES_SVH
`define DEFRAG_GAP_RUN_SELECTOR_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define DGRS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dgrs same-cycle check failed");

// condition holds in the cycle after the trigger
`define DGRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dgrs next-cycle check failed");

`endif

// File: rtl/dgrs_pkg.sv
// types and constants for the gap run selector
package dgrs_pkg;

    localparam int HANDLE_BITS   = 48;
    localparam int CFG_BITS      = 5;
    localparam logic [CFG_BITS-1:0] MAX_RUN_RESET = 5'd4;

    // one scanned chunk
    typedef struct packed {
        logic [HANDLE_BITS-1:0] chunk_handle;
        logic                   chunk_used;
    } chunk_in_t;

    // one relocation candidate or error word
    typedef struct packed {
        logic [HANDLE_BITS-1:0] move_handle;
        logic                   last_in_run;
        logic                   double_free_error;
    } move_out_t;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } seq_state_t;

endpackage

// File: rtl/dgrs_ram.sv
// generic simple dual port ram with registered read
module dgrs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/defrag_gap_run_selector.sv
// top level of the gap run selector: scan control, hold memory and output register
//
// A chunk that does not release a held run (any chunk in search state, a used
// chunk in match state, or a double free) needs no readout, so such chunks
// stream at one per cycle while the output register is free. A free chunk that
// releases N held handles starts the emit state, which reads the handles out
// of the hold memory through its single read port, one per cycle while the
// output register is free; s_ready is low during that readout and whenever
// the output register holds a word that has not been taken. The hold memory
// needs no clearing after reset: only entries below the held count are read.
`include "defrag_gap_run_selector_defines.svh"

module defrag_gap_run_selector #(
    parameter int HOLD_DEPTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // chunk input
    input  logic                        s_valid,
    output logic                        s_ready,
    input  dgrs_pkg::chunk_in_t         s_data,
    // candidate output
    output logic                        m_valid,
    input  logic                        m_ready,
    output dgrs_pkg::move_out_t         m_data,
    // run limit register
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dgrs_pkg::CFG_BITS-1:0] cfg_data
);

    localparam int IW   = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CW   = $clog2(HOLD_DEPTH + 1);
    localparam int CMPW = (CW > dgrs_pkg::CFG_BITS) ? CW : dgrs_pkg::CFG_BITS;

    dgrs_pkg::seq_state_t             state_reg, state_next;
    logic                             match_mode_reg, match_mode_next;
    logic [CW-1:0]                    held_count_reg, held_count_next;
    logic [IW-1:0]                    rd_idx_reg, rd_idx_next;
    logic [dgrs_pkg::CFG_BITS-1:0]    max_run_reg;
    logic                             m_valid_reg, m_valid_next;
    dgrs_pkg::move_out_t              m_data_reg, m_data_next;

    logic                             out_free;
    logic                             in_acc;
    logic                             can_hold;
    logic                             is_last;
    logic                             start_emit;
    logic                             emit_load;
    logic                             emit_done;
    logic                             err_load;
    logic                             hold_wr;
    logic [dgrs_pkg::HANDLE_BITS-1:0] hold_rd_data;

    // hold memory for the current run of used chunks
    dgrs_ram #(
        .WIDTH (dgrs_pkg::HANDLE_BITS),
        .DEPTH (HOLD_DEPTH)
    ) u_hold (
        .aclk    (aclk),
        .wr_en   (hold_wr),
        .wr_addr (held_count_reg[IW-1:0]),
        .wr_data (s_data.chunk_handle),
        .rd_addr (rd_idx_next),
        .rd_data (hold_rd_data)
    );

    // run limit register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_run_reg <= dgrs_pkg::MAX_RUN_RESET;
        end else if (cfg_valid) begin
            max_run_reg <= cfg_data;
        end
    end

    // shared status terms
    assign out_free = !m_valid_reg || m_ready;
    assign in_acc   = s_valid && s_ready;
    assign can_hold = (CMPW'(held_count_reg) < CMPW'(max_run_reg))
                   && (CMPW'(held_count_reg) < CMPW'(HOLD_DEPTH));
    assign is_last  = (CW'(rd_idx_reg) + CW'(1)) == held_count_reg;

    // sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        emit_load = 1'b0;
        unique case (state_reg)
            dgrs_pkg::ST_IDLE: begin
                s_ready = out_free;
            end
            dgrs_pkg::ST_EMIT: begin
                emit_load = out_free;
            end
            default: begin
                s_ready   = 1'b0;
                emit_load = 1'b0;
            end
        endcase
    end

    // scan decisions for an accepted chunk
    always_comb begin
        match_mode_next = match_mode_reg;
        held_count_next = held_count_reg;
        hold_wr         = 1'b0;
        start_emit      = 1'b0;
        err_load        = 1'b0;
        emit_done       = emit_load && is_last;
        if (in_acc) begin
            priority if (!match_mode_reg) begin
                match_mode_next = !s_data.chunk_used;
            end else if (s_data.chunk_used) begin
                if (can_hold) begin
                    hold_wr         = 1'b1;
                    held_count_next = held_count_reg + CW'(1);
                end else begin
                    held_count_next = '0;
                    match_mode_next = 1'b0;
                end
            end else if (held_count_reg == '0) begin
                err_load = 1'b1;
            end else begin
                start_emit = 1'b1;
            end
        end
        if (emit_done) begin
            held_count_next = '0;
        end
    end

    // read index walks the held run
    always_comb begin
        rd_idx_next = rd_idx_reg;
        if (start_emit) begin
            rd_idx_next = '0;
        end else if (emit_load) begin
            rd_idx_next = rd_idx_reg + IW'(1);
        end
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dgrs_pkg::ST_IDLE: begin
                if (start_emit) begin
                    state_next = dgrs_pkg::ST_EMIT;
                end
            end
            dgrs_pkg::ST_EMIT: begin
                if (emit_done) begin
                    state_next = dgrs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dgrs_pkg::ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        priority if (err_load) begin
            m_valid_next                  = 1'b1;
            m_data_next.move_handle       = s_data.chunk_handle;
            m_data_next.last_in_run       = 1'b1;
            m_data_next.double_free_error = 1'b1;
        end else if (emit_load) begin
            m_valid_next                  = 1'b1;
            m_data_next.move_handle       = hold_rd_data;
            m_data_next.last_in_run       = is_last;
            m_data_next.double_free_error = 1'b0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dgrs_pkg::ST_IDLE;
            match_mode_reg <= 1'b0;
            held_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            match_mode_reg <= match_mode_next;
            held_count_reg <= held_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks on the scan control
    `DGRS_ASSERT_SAME(a_held_in_range, aclk, aresetn, 1'b1, held_count_reg <= CW'(HOLD_DEPTH))
    `DGRS_ASSERT_SAME(a_held_needs_match, aclk, aresetn, held_count_reg != '0, match_mode_reg)
    `DGRS_ASSERT_SAME(a_emit_has_run, aclk, aresetn, state_reg == dgrs_pkg::ST_EMIT, held_count_reg != '0 && !s_ready)
    `DGRS_ASSERT_NEXT(a_emit_ends_clean, aclk, aresetn, emit_done, held_count_reg == '0 && state_reg == dgrs_pkg::ST_IDLE && m_valid_reg && m_data_reg.last_in_run)

endmodule

// File: tb/gap_run_checker.sv
`timescale 1ns / 100ps
// checker for the gap run selector: tracks the scan state and compares relocation words
module gap_run_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  dgrs_pkg::chunk_in_t           s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  dgrs_pkg::move_out_t           m_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [dgrs_pkg::CFG_BITS-1:0] cfg_data,
    output int unsigned                   fail_count,
    output int unsigned                   pending
);

    localparam int HOLD_DEPTH  = 16;
    localparam int MAX_REPORTS = 10;

    typedef enum bit {
        SCAN_SEARCH,
        SCAN_MATCH
    } scan_mode_t;

    scan_mode_t                       scan_mode;
    logic [dgrs_pkg::CFG_BITS-1:0]    run_limit;
    int unsigned                      held_count;
    logic [dgrs_pkg::HANDLE_BITS-1:0] held_handles [HOLD_DEPTH];
    dgrs_pkg::move_out_t              expected_moves [$];

    // run limit as the hold memory can honor it
    function automatic int unsigned hold_limit();
        return (run_limit > HOLD_DEPTH) ? HOLD_DEPTH : run_limit;
    endfunction

    // advance the scan by one chunk and queue the words it releases
    task automatic predict_chunk(input dgrs_pkg::chunk_in_t chunk);
        dgrs_pkg::move_out_t word;
        if (scan_mode == SCAN_SEARCH) begin
            // first free chunk opens a gap
            if (!chunk.chunk_used) scan_mode = SCAN_MATCH;
        end else if (chunk.chunk_used) begin
            // hold the used chunk, or give up when the run is too long
            if (held_count < hold_limit()) begin
                held_handles[held_count] = chunk.chunk_handle;
                held_count++;
            end else begin
                held_count = 0;
                scan_mode  = SCAN_SEARCH;
            end
        end else if (held_count == 0) begin
            // free chunk right after a free chunk
            word.move_handle       = chunk.chunk_handle;
            word.last_in_run       = 1'b1;
            word.double_free_error = 1'b1;
            expected_moves.push_back(word);
        end else begin
            // release the held run in address order
            for (int i = 0; i < held_count; i++) begin
                word.move_handle       = held_handles[i];
                word.last_in_run       = (i + 1 == held_count);
                word.double_free_error = 1'b0;
                expected_moves.push_back(word);
            end
            held_count = 0;
        end
    endtask

    // watch all three channels at each edge
    always @(posedge aclk) begin : watch
        dgrs_pkg::move_out_t want;
        if (!aresetn) begin
            scan_mode  = SCAN_SEARCH;
            run_limit  = dgrs_pkg::MAX_RUN_RESET;
            held_count = 0;
            fail_count = 0;
            expected_moves.delete();
        end else begin
            if (cfg_valid && cfg_ready) run_limit = cfg_data;
            if (s_valid && s_ready) predict_chunk(s_data);
            if (m_valid && m_ready) begin
                if (expected_moves.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected word handle=%h last=%b err=%b", $realtime,
                                 m_data.move_handle, m_data.last_in_run,
                                 m_data.double_free_error);
                end else begin
                    want = expected_moves.pop_front();
                    if (m_data.move_handle !== want.move_handle ||
                        m_data.last_in_run !== want.last_in_run ||
                        m_data.double_free_error !== want.double_free_error) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: expected %h/%b/%b, got %h/%b/%b", $realtime,
                                     want.move_handle, want.last_in_run,
                                     want.double_free_error, m_data.move_handle,
                                     m_data.last_in_run, m_data.double_free_error);
                    end
                end
            end
        end
        pending <= expected_moves.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// top of the gap run selector testbench: clock, reset, chunk stimulus and verdict
module tb_top;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 16;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    dgrs_pkg::chunk_in_t           s_data    = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    dgrs_pkg::move_out_t           m_data;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [dgrs_pkg::CFG_BITS-1:0] cfg_data  = '0;

    int unsigned         fail_count;
    int unsigned         pending;
    int                  send_idle_pct = 30;
    int                  recv_idle_pct = 58;
    int unsigned         cur_limit     = dgrs_pkg::MAX_RUN_RESET;
    logic                hold_req      = 1'b0;
    int unsigned         hold_left     = 0;

    always #4 aclk = ~aclk;

    defrag_gap_run_selector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    gap_run_checker u_run_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left <= HOLD_OFF_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // random handle with the extremes mixed in
    function automatic logic [dgrs_pkg::HANDLE_BITS-1:0] rand_handle();
        int unsigned pick;
        logic [63:0] wide;
        pick = $urandom_range(0, 99);
        wide = {$urandom, $urandom};
        if (pick < 8) return '1;
        if (pick < 12) return '0;
        return wide[dgrs_pkg::HANDLE_BITS-1:0];
    endfunction

    // offer one chunk word and wait until it is taken
    task automatic send_chunk(input logic [dgrs_pkg::HANDLE_BITS-1:0] handle,
                              input logic used);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_data  <= '{chunk_handle: handle, chunk_used: used};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop sending and wait for every expected word to come out
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write the run limit while the block is idle
    task automatic write_run_limit(input logic [dgrs_pkg::CFG_BITS-1:0] value);
        settle();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_limit = value;
    endtask

    // mostly gap / used run / gap sequences, some random noise
    task automatic send_runs(input int unsigned n_items);
        int unsigned sent;
        int unsigned eff;
        int unsigned k;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 15) begin
                repeat ($urandom_range(1, 4)) begin
                    send_chunk(rand_handle(), 1'($urandom_range(0, 1)));
                    sent++;
                end
            end else begin
                eff = (cur_limit > 16) ? 16 : cur_limit;
                k = ($urandom_range(0, 99) < 20) ? eff + 1 : $urandom_range(0, eff);
                repeat (k) begin
                    send_chunk(rand_handle(), 1'b1);
                    sent++;
                end
                send_chunk(rand_handle(), 1'b0);
                sent++;
            end
        end
    endtask

    // stimulus
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // used chunk in search, gap opens, then a double free
        send_chunk('0, 1'b1);
        send_chunk('1, 1'b0);
        send_chunk(48'h0000_0000_0001, 1'b0);
        // full run at the reset limit, released by a free chunk
        send_chunk('1, 1'b1);
        send_chunk('0, 1'b1);
        send_chunk(48'h5555_5555_5555, 1'b1);
        send_chunk(48'hAAAA_AAAA_AAAA, 1'b1);
        send_chunk(48'h1234_5678_9ABC, 1'b0);
        // one used chunk too many drops the run
        repeat (5) send_chunk(rand_handle(), 1'b1);
        send_chunk(rand_handle(), 1'b0);
        // limit lowered with three held: free chunk still releases all three
        repeat (3) send_chunk(rand_handle(), 1'b1);
        write_run_limit(5'd2);
        send_chunk(rand_handle(), 1'b0);
        // limit lowered below the held count: next used chunk drops the run
        repeat (2) send_chunk(rand_handle(), 1'b1);
        write_run_limit(5'd1);
        send_chunk(rand_handle(), 1'b1);
        send_chunk(rand_handle(), 1'b0);
        // zero limit: any used chunk in match returns to search
        write_run_limit(5'd0);
        send_chunk(rand_handle(), 1'b1);
        send_chunk(rand_handle(), 1'b0);
        send_chunk(rand_handle(), 1'b0);

        // sender idles lightly, receiver heavily
        write_run_limit(5'd16);
        send_runs(20);
        write_run_limit(5'd31);
        send_runs(20);

        // the other way round
        send_idle_pct = 58;
        recv_idle_pct = 30;
        write_run_limit(5'd1);
        send_runs(15);
        write_run_limit(5'd17);
        send_runs(15);

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_run_limit(5'd0);
        send_runs(10);
        // receiver holds off while short runs keep coming
        write_run_limit(5'd3);
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        send_runs(25);
        settle();
        write_run_limit(5'($urandom_range(1, 16)));
        send_runs(15);

        // drain and give the verdict
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
